>>> rtl/core/cdf_pkg.sv
// Package: shared constants, the input word type and the CRC-16 byte update for the record deframer.
`default_nettype none

package cdf_pkg;

    // Fixed field and state widths
    localparam int POS_W  = 6;
    localparam int BYTE_W = 8;
    localparam int CRC_W  = 16;
    localparam int CNT_W  = 32;

    // Default record layout
    localparam int RECORD_BYTES_DEF = 34;
    localparam int DATA_BYTES_DEF   = 32;

    // CRC-16/CMS: MSB first, no reflection, no final xor
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8005;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    // Saturation value of the record counters
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Word held in the input register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              start;
    } item_t;

    // One byte through the CRC, MSB first
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] octet);
        logic [CRC_W-1:0] crc;
        logic             top;
        crc = crc_in;
        for (int i = 0; i < BYTE_W; i++)
        begin
            top = crc[CRC_W-1] ^ octet[BYTE_W-1-i];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (top)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/cdf_ifs.sv
// Interfaces: byte input channel and record result channel.
`default_nettype none

interface cdf_in_if;
    logic                       valid;
    logic                       ready;
    logic [cdf_pkg::BYTE_W-1:0] data_in;
    logic                       section_start;

    modport source (output valid, data_in, section_start, input ready);
    modport sink   (input valid, data_in, section_start, output ready);
endinterface

interface cdf_out_if;
    logic                       valid;
    logic                       ready;
    logic [cdf_pkg::BYTE_W-1:0] data_out;
    logic                       data_valid;
    logic                       record_done;
    logic                       crc_match;
    logic [cdf_pkg::CNT_W-1:0]  good_records;
    logic [cdf_pkg::CNT_W-1:0]  bad_records;

    modport source (output valid, data_out, data_valid, record_done, crc_match,
                    good_records, bad_records, input ready);
    modport sink   (input valid, data_out, data_valid, record_done, crc_match,
                    good_records, bad_records, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cdf_in_stage.sv
// Input register: captures one byte word per cycle unless the record core stalls, and hands it to the record core.
`default_nettype none

module cdf_in_stage (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cdf_in_if.sink        byte_in,
    output cdf_pkg::item_t item,
    input  wire logic     item_ready
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [cdf_pkg::BYTE_W-1:0] data_reg;
    logic                       start_reg;

    // Take a word whenever the register is empty or drains this cycle
    assign byte_in.ready = !valid_reg || item_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_in.ready)
        begin
            valid_next = byte_in.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid)
        begin
            data_reg  <= byte_in.data_in;
            start_reg <= byte_in.section_start;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;
    assign item.start = start_reg;

endmodule

`default_nettype wire

>>> rtl/core/cdf_core.sv
// Record core: position tracking, running CRC, check on the low CRC byte, counters, result register.
`default_nettype none

module cdf_core #(
    parameter int RECORD_BYTES = cdf_pkg::RECORD_BYTES_DEF,
    parameter int DATA_BYTES   = cdf_pkg::DATA_BYTES_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  cdf_pkg::item_t item,
    output logic           item_ready,
    cdf_out_if.source      rec_out
);

    localparam logic [cdf_pkg::POS_W-1:0] HI_POS   = cdf_pkg::POS_W'(DATA_BYTES);
    localparam logic [cdf_pkg::POS_W-1:0] LO_POS   = cdf_pkg::POS_W'(DATA_BYTES + 1);
    localparam logic [cdf_pkg::POS_W-1:0] LAST_POS = cdf_pkg::POS_W'(RECORD_BYTES - 1);

    // Record state
    logic [cdf_pkg::POS_W-1:0]  pos_reg,  pos_next;
    logic [cdf_pkg::CRC_W-1:0]  crc_reg,  crc_next;
    logic [cdf_pkg::BYTE_W-1:0] hi_reg,   hi_next;
    logic [cdf_pkg::CNT_W-1:0]  good_reg, good_next;
    logic [cdf_pkg::CNT_W-1:0]  bad_reg,  bad_next;

    // Result register
    logic                       out_valid_reg, out_valid_next;
    logic [cdf_pkg::BYTE_W-1:0] dout_reg,  dout_next;
    logic                       dval_reg,  dval_next;
    logic                       done_reg,  done_next;
    logic                       match_reg, match_next;

    logic                       fire;
    logic [cdf_pkg::POS_W-1:0]  pos_cur;
    logic [cdf_pkg::CRC_W-1:0]  crc_cur;
    logic                       is_payload;
    logic                       is_hi;
    logic                       is_lo;
    logic                       crc_eq;

    // Advance when the result register is free or being emptied
    assign item_ready = !out_valid_reg || rec_out.ready;
    assign fire       = item.valid && item_ready;

    // Section start restarts the record before the byte is handled
    assign pos_cur    = item.start ? '0 : pos_reg;
    assign crc_cur    = item.start ? cdf_pkg::CRC_INIT : crc_reg;
    assign is_payload = pos_cur < HI_POS;
    assign is_hi      = pos_cur == HI_POS;
    assign is_lo      = pos_cur == LO_POS;
    assign crc_eq     = {hi_reg, item.data} == crc_cur;

    // Next record state and result
    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        hi_next        = hi_reg;
        good_next      = good_reg;
        bad_next       = bad_reg;
        dout_next      = dout_reg;
        dval_next      = dval_reg;
        done_next      = done_reg;
        match_next     = match_reg;
        out_valid_next = out_valid_reg && !rec_out.ready;

        if (fire)
        begin
            out_valid_next = 1'b1;
            dout_next      = is_payload ? item.data : '0;
            dval_next      = is_payload;
            done_next      = is_lo;
            match_next     = is_lo && crc_eq;
            crc_next       = is_payload ? cdf_pkg::crc_feed(crc_cur, item.data) : crc_cur;

            if (is_hi)
            begin
                hi_next = item.data;
            end

            // Saturating record counters
            if (is_lo && crc_eq && good_reg != cdf_pkg::CNT_MAX)
            begin
                good_next = good_reg + 1'b1;
            end
            if (is_lo && !crc_eq && bad_reg != cdf_pkg::CNT_MAX)
            begin
                bad_next = bad_reg + 1'b1;
            end

            // Wrap at record end
            if (pos_cur >= LAST_POS)
            begin
                pos_next = '0;
                crc_next = cdf_pkg::CRC_INIT;
            end
            else
            begin
                pos_next = pos_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            crc_reg       <= cdf_pkg::CRC_INIT;
            hi_reg        <= '0;
            good_reg      <= '0;
            bad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            hi_reg        <= hi_next;
            good_reg      <= good_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        dout_reg  <= dout_next;
        dval_reg  <= dval_next;
        done_reg  <= done_next;
        match_reg <= match_next;
    end

    // Counters only change together with a new result, so they drive the port directly
    assign rec_out.valid        = out_valid_reg;
    assign rec_out.data_out     = dout_reg;
    assign rec_out.data_valid   = dval_reg;
    assign rec_out.record_done  = done_reg;
    assign rec_out.crc_match    = match_reg;
    assign rec_out.good_records = good_reg;
    assign rec_out.bad_records  = bad_reg;

    // Checks
    a_done_not_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> !dval_reg)
        else $error("record_done on a payload word");

    a_match_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && match_reg |-> done_reg)
        else $error("crc_match without record_done");

    a_pos_in_record: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("byte position beyond record end");

    a_good_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> good_reg >= $past(good_reg))
        else $error("good record counter decreased");

    a_counters_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(good_reg) && $stable(bad_reg))
        else $error("counter changed without a word");

endmodule

`default_nettype wire

>>> rtl/core/crc_checked_record_deframer.sv
// Top level: CRC-checked record deframer, input register plus record core.
//
//  channel   dir  modport          payload
//  byte_in   in   cdf_in_if.sink   data_in[7:0], section_start
//  rec_out   out  cdf_out_if.source data_out[7:0], data_valid, record_done, crc_match,
//                                  good_records[31:0], bad_records[31:0]
//
// One byte word per cycle sustained while rec_out is ready; a taken word passes the input
// register and then the result register on its way to the output handshake.
// The CRC-16 byte update sits between the input register and the result register.
// Reset clears position, CRC (to 0xFFFF), stored high byte and both counters.
// A stalled rec_out holds its result; byte_in still fills the input register, then stalls.
`default_nettype none

module crc_checked_record_deframer #(
    parameter int RECORD_BYTES = cdf_pkg::RECORD_BYTES_DEF,
    parameter int DATA_BYTES   = cdf_pkg::DATA_BYTES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cdf_in_if.sink    byte_in,
    cdf_out_if.source rec_out
);

    cdf_pkg::item_t item;
    logic           item_ready;

    cdf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .item       (item),
        .item_ready (item_ready)
    );

    cdf_core #(
        .RECORD_BYTES (RECORD_BYTES),
        .DATA_BYTES   (DATA_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_ready (item_ready),
        .rec_out    (rec_out)
    );

endmodule

`default_nettype wire
